>>> sv/uer_pkg.sv
// Package for the ultrasonic echo ranger: register indexes, reset values,
// and the configuration and result structs shared by the modules.
// No dependencies.
package uer_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 20;

   localparam logic [CsrIndexWidth-1:0] CSR_PULSE_COUNT     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PULSE_HALF_US   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_COUNT_PERIOD_US = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_WINDOW_US       = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_DISTANCE    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_SCALE_Q16       = 3'd5;

   localparam logic [3:0]  PULSE_COUNT_RESET     = 4'd4;
   localparam logic [7:0]  PULSE_HALF_US_RESET   = 8'd12;
   localparam logic [7:0]  COUNT_PERIOD_US_RESET = 8'd5;
   localparam logic [19:0] WINDOW_US_RESET       = 20'd100000;
   localparam logic [15:0] MAX_DISTANCE_RESET    = 16'd32000;
   localparam logic [15:0] SCALE_Q16_RESET       = 16'd9284;

   typedef struct packed {
      logic [3:0]  pulse_count;
      logic [7:0]  pulse_half_us;
      logic [7:0]  count_period_us;
      logic [19:0] window_us;
      logic [15:0] max_distance_x16;
      logic [15:0] scale_q16;
   } cfg_type;

   typedef struct packed {
      logic        trig_level;
      logic        busy_res;
      logic        done_res;
      logic        no_echo;
      logic [15:0] distance_x16;
   } result_type;

endpackage

>>> sv/uer_csr.sv
// Configuration register file of the echo ranger.
// Depends on uer_pkg for register indexes, reset values and cfg_type.
module uer_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [uer_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [uer_pkg::CsrDataWidth-1:0]  csr_data,
   output uer_pkg::cfg_type                  cfg
);

   uer_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_count      <= uer_pkg::PULSE_COUNT_RESET;
         cfg_ff.pulse_half_us    <= uer_pkg::PULSE_HALF_US_RESET;
         cfg_ff.count_period_us  <= uer_pkg::COUNT_PERIOD_US_RESET;
         cfg_ff.window_us        <= uer_pkg::WINDOW_US_RESET;
         cfg_ff.max_distance_x16 <= uer_pkg::MAX_DISTANCE_RESET;
         cfg_ff.scale_q16        <= uer_pkg::SCALE_Q16_RESET;
      end else if (csr_write) begin
         // Indexes beyond the register list are dropped.
         unique case (csr_index)
            uer_pkg::CSR_PULSE_COUNT:     cfg_ff.pulse_count      <= csr_data[3:0];
            uer_pkg::CSR_PULSE_HALF_US:   cfg_ff.pulse_half_us    <= csr_data[7:0];
            uer_pkg::CSR_COUNT_PERIOD_US: cfg_ff.count_period_us  <= csr_data[7:0];
            uer_pkg::CSR_WINDOW_US:       cfg_ff.window_us        <= csr_data;
            uer_pkg::CSR_MAX_DISTANCE:    cfg_ff.max_distance_x16 <= csr_data[15:0];
            uer_pkg::CSR_SCALE_Q16:       cfg_ff.scale_q16        <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/uer_core.sv
// Measurement sequencer of the echo ranger: phase, counters and the
// distance calculation, advanced by one word per step. Depends on uer_pkg.
module uer_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                start_req,
   input  logic                echo_level,
   input  uer_pkg::cfg_type    cfg,
   output uer_pkg::result_type result
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_BURST  = 2'd1;
   localparam logic [1:0] PH_WINDOW = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  pulse_index_ff, pulse_index_in;
   logic [19:0] micro_ff, micro_in;
   logic [7:0]  prescale_ff, prescale_in;
   logic [15:0] ticks_ff, ticks_in;
   logic        seen_ff, seen_in;
   logic        prev_ff;
   logic [15:0] last_good_ff, last_good_in;

   logic [7:0]  half;
   logic [3:0]  pulses;
   logic [7:0]  period;
   logic [19:0] window;
   logic [19:0] micro_inc;
   logic [7:0]  prescale_inc;
   logic        falling;
   logic [31:0] product;
   logic [19:0] dist_raw;
   logic [15:0] dist_clamped;
   logic [15:0] dist_final;

   // Zero register values act as one.
   assign half   = (cfg.pulse_half_us == 8'd0) ? 8'd1 : cfg.pulse_half_us;
   assign pulses = (cfg.pulse_count == 4'd0) ? 4'd1 : cfg.pulse_count;
   assign period = (cfg.count_period_us == 8'd0) ? 8'd1 : cfg.count_period_us;
   assign window = (cfg.window_us == 20'd0) ? 20'd1 : cfg.window_us;

   assign micro_inc    = micro_ff + 20'd1;
   assign prescale_inc = prescale_ff + 8'd1;
   assign falling      = prev_ff & ~echo_level;

   // The count is frozen whenever the window closes with an echo, so the
   // registered count is the one to scale.
   assign product      = {16'd0, ticks_ff} * {16'd0, cfg.scale_q16};
   assign dist_raw     = product[31:12];
   assign dist_clamped = (dist_raw > {4'd0, cfg.max_distance_x16}) ?
                         cfg.max_distance_x16 : dist_raw[15:0];
   assign dist_final   = (dist_clamped == 16'd0) ? last_good_ff : dist_clamped;

   always_comb begin
      phase_in       = phase_ff;
      pulse_index_in = pulse_index_ff;
      micro_in       = micro_ff;
      prescale_in    = prescale_ff;
      ticks_in       = ticks_ff;
      seen_in        = seen_ff;
      last_good_in   = last_good_ff;
      result         = '0;

      unique case (phase_ff)
         PH_BURST: begin
            result.busy_res   = 1'b1;
            result.trig_level = (micro_ff < {12'd0, half});
            micro_in          = micro_inc;
            if (micro_inc >= {11'd0, half, 1'b0}) begin
               micro_in = 20'd0;
               if ({1'b0, pulse_index_ff} + 5'd1 >= {1'b0, pulses}) begin
                  pulse_index_in = 4'd0;
                  phase_in       = PH_WINDOW;
               end else begin
                  pulse_index_in = pulse_index_ff + 4'd1;
               end
            end
         end
         PH_WINDOW: begin
            result.busy_res = 1'b1;
            if (!seen_ff && falling) begin
               seen_in = 1'b1;
            end else if (!seen_ff) begin
               prescale_in = prescale_inc;
               if (prescale_inc >= period) begin
                  prescale_in = 8'd0;
                  if (ticks_ff != 16'hFFFF) begin
                     ticks_in = ticks_ff + 16'd1;
                  end
               end
            end
            micro_in = micro_inc;
            if (micro_inc == 20'd0 || micro_inc >= window) begin
               result.busy_res = 1'b0;
               result.done_res = 1'b1;
               phase_in        = PH_IDLE;
               micro_in        = 20'd0;
               if (seen_in) begin
                  result.distance_x16 = dist_final;
                  last_good_in        = dist_final;
               end else begin
                  result.no_echo = 1'b1;
               end
            end
         end
         default: begin
            // Idle, and the unused phase code behaves as idle.
            phase_in = PH_IDLE;
            if (start_req) begin
               phase_in        = PH_BURST;
               result.busy_res = 1'b1;
               pulse_index_in  = 4'd0;
               micro_in        = 20'd0;
               prescale_in     = 8'd0;
               ticks_in        = 16'd0;
               seen_in         = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         pulse_index_ff <= 4'd0;
         micro_ff       <= 20'd0;
         prescale_ff    <= 8'd0;
         ticks_ff       <= 16'd0;
         seen_ff        <= 1'b0;
         prev_ff        <= 1'b0;
         last_good_ff   <= 16'd0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         pulse_index_ff <= pulse_index_in;
         micro_ff       <= micro_in;
         prescale_ff    <= prescale_in;
         ticks_ff       <= ticks_in;
         seen_ff        <= seen_in;
         prev_ff        <= echo_level;
         last_good_ff   <= last_good_in;
      end
   end

endmodule

>>> sv/ultrasonic_echo_ranger_unit.sv
// Top level of the ultrasonic echo ranger: register file, input word register,
// sequencer and result register. Depends on uer_pkg, uer_csr and uer_core.
//
// Usage: each request word is one microsecond tick carrying start_req and
// the sampled echo pin level. Every accepted word yields exactly one
// response word with the trigger drive level, busy, done, no_echo and the
// distance in sixteenths (valid with done when no_echo is low).
// Both channels use valid/ready. A word waits in the input register and then
// steps the sequencer into the result register; throughput is one word per
// cycle while the receiver keeps taking words and does not stall.
// The sequencer state advances only when a word moves into the result
// register, so it runs at the word rate, not the clock rate.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; then req_ready drops until the result
// is taken. Reset (synchronous, active high) empties both registers, puts
// the sequencer in idle and loads the register reset values.
// Configuration writes through csr_write/csr_index/csr_data take effect at
// the next clock edge, with no wait; indexes past the list are ignored.
module ultrasonic_echo_ranger_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_start_req,
   input  logic                              req_echo_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_trig_level,
   output logic                              rsp_busy_res,
   output logic                              rsp_done_res,
   output logic                              rsp_no_echo,
   output logic [15:0]                       rsp_distance_x16,
   input  logic                              csr_write,
   input  logic [uer_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [uer_pkg::CsrDataWidth-1:0]  csr_data
);

   uer_pkg::cfg_type    cfg;
   uer_pkg::result_type step_result;
   uer_pkg::result_type out_ff;

   logic in_valid_ff;
   logic in_start_ff;
   logic in_echo_ff;
   logic out_valid_ff;
   logic advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   uer_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   uer_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .start_req  (in_start_ff),
      .echo_level (in_echo_ff),
      .cfg        (cfg),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_start_ff <= req_start_req;
         in_echo_ff  <= req_echo_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_trig_level   = out_ff.trig_level;
   assign rsp_busy_res     = out_ff.busy_res;
   assign rsp_done_res     = out_ff.done_res;
   assign rsp_no_echo      = out_ff.no_echo;
   assign rsp_distance_x16 = out_ff.distance_x16;

   // A word waiting in the input register must not be lost while stalled.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_start_ff))
      else $error("input word dropped during stall");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.done_res |-> !out_ff.busy_res)
      else $error("done reported while busy");

   a_no_echo_with_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.no_echo |-> out_ff.done_res && out_ff.distance_x16 == 16'd0)
      else $error("no_echo without done or with a distance");

   a_trig_while_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.trig_level |-> out_ff.busy_res)
      else $error("trigger driven while idle");

endmodule

>>> tb/uer_result_checker.sv
`timescale 1ns / 100ps
// Response checker for the ultrasonic echo ranger unit. It samples both channels and
// the register port at the falling clock edge, predicts each response word and
// compares it field by field. Depends on uer_pkg.
module uer_result_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_start_req,
   input  logic                              req_echo_level,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_trig_level,
   input  logic                              rsp_busy_res,
   input  logic                              rsp_done_res,
   input  logic                              rsp_no_echo,
   input  logic [15:0]                       rsp_distance_x16,
   input  logic                              csr_write,
   input  logic [uer_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [uer_pkg::CsrDataWidth-1:0]  csr_data,
   output int                                fail_count,
   output int                                pending,
   output logic                              seq_idle,
   output int                                done_count,
   output int                                no_echo_count
);

   typedef enum logic [1:0] {
      RANGER_IDLE,
      RANGER_BURST,
      RANGER_WINDOW
   } ranger_phase_type;

   ranger_phase_type    ranger_phase;
   uer_pkg::cfg_type    cfg;
   logic [3:0]          pulse_index;
   logic [19:0]         micro_count;
   logic [7:0]          prescale;
   logic [15:0]         echo_ticks;
   logic [15:0]         last_good;
   logic                echo_seen;
   logic                echo_prev;
   uer_pkg::result_type expected_words[$];
   uer_pkg::result_type predicted;
   uer_pkg::result_type wanted;
   int                  rsp_index;

   initial begin
      fail_count    = 0;
      pending       = 0;
      seq_idle      = 1'b1;
      done_count    = 0;
      no_echo_count = 0;
      rsp_index     = 0;
   end

   task automatic flag_error(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("ERROR: %s", msg);
   endtask

   // Advances the ranger by one microsecond word and returns the response it gives.
   task automatic step_ranger(input logic start, input logic level,
                              output uer_pkg::result_type r);
      logic        falling;
      logic [3:0]  pulses;
      logic [7:0]  half;
      logic [7:0]  period;
      logic [19:0] win;
      logic [31:0] product;
      falling = echo_prev && !level;
      pulses  = (cfg.pulse_count == '0) ? 4'd1 : cfg.pulse_count;
      half    = (cfg.pulse_half_us == '0) ? 8'd1 : cfg.pulse_half_us;
      period  = (cfg.count_period_us == '0) ? 8'd1 : cfg.count_period_us;
      win     = (cfg.window_us == '0) ? 20'd1 : cfg.window_us;
      r = '0;
      case (ranger_phase)
         RANGER_BURST: begin
            r.busy_res   = 1'b1;
            r.trig_level = (micro_count < {12'd0, half});
            micro_count  = micro_count + 20'd1;
            if (micro_count >= {11'd0, half, 1'b0}) begin
               micro_count = '0;
               if ({1'b0, pulse_index} + 5'd1 >= {1'b0, pulses}) begin
                  pulse_index  = '0;
                  ranger_phase = RANGER_WINDOW;
               end else begin
                  pulse_index = pulse_index + 4'd1;
               end
            end
         end
         RANGER_WINDOW: begin
            r.busy_res = 1'b1;
            // The first falling edge freezes the count; no tick is added on that word.
            if (!echo_seen && falling) begin
               echo_seen = 1'b1;
            end else if (!echo_seen) begin
               prescale = prescale + 8'd1;
               if (prescale >= period) begin
                  prescale = '0;
                  if (echo_ticks != 16'hFFFF)
                     echo_ticks = echo_ticks + 16'd1;
               end
            end
            micro_count = micro_count + 20'd1;
            if (micro_count == '0 || micro_count >= win) begin
               r.busy_res   = 1'b0;
               r.done_res   = 1'b1;
               ranger_phase = RANGER_IDLE;
               micro_count  = '0;
               if (echo_seen) begin
                  product = ({16'd0, echo_ticks} * {16'd0, cfg.scale_q16}) >> 12;
                  if (product > {16'd0, cfg.max_distance_x16})
                     product = {16'd0, cfg.max_distance_x16};
                  // A zero distance repeats the last good one.
                  if (product == '0)
                     product = {16'd0, last_good};
                  r.distance_x16 = product[15:0];
                  last_good      = product[15:0];
               end else begin
                  r.no_echo = 1'b1;
               end
            end
         end
         default: begin
            ranger_phase = RANGER_IDLE;
            if (start) begin
               ranger_phase = RANGER_BURST;
               r.busy_res   = 1'b1;
               pulse_index  = '0;
               micro_count  = '0;
               prescale     = '0;
               echo_ticks   = '0;
               echo_seen    = 1'b0;
            end
         end
      endcase
      echo_prev = level;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         cfg = '{pulse_count: uer_pkg::PULSE_COUNT_RESET,
                 pulse_half_us: uer_pkg::PULSE_HALF_US_RESET,
                 count_period_us: uer_pkg::COUNT_PERIOD_US_RESET,
                 window_us: uer_pkg::WINDOW_US_RESET,
                 max_distance_x16: uer_pkg::MAX_DISTANCE_RESET,
                 scale_q16: uer_pkg::SCALE_Q16_RESET};
         ranger_phase = RANGER_IDLE;
         pulse_index  = '0;
         micro_count  = '0;
         prescale     = '0;
         echo_ticks   = '0;
         echo_seen    = 1'b0;
         echo_prev    = 1'b0;
         last_good    = '0;
         expected_words.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               uer_pkg::CSR_PULSE_COUNT:     cfg.pulse_count      = csr_data[3:0];
               uer_pkg::CSR_PULSE_HALF_US:   cfg.pulse_half_us    = csr_data[7:0];
               uer_pkg::CSR_COUNT_PERIOD_US: cfg.count_period_us  = csr_data[7:0];
               uer_pkg::CSR_WINDOW_US:       cfg.window_us        = csr_data[19:0];
               uer_pkg::CSR_MAX_DISTANCE:    cfg.max_distance_x16 = csr_data[15:0];
               uer_pkg::CSR_SCALE_Q16:       cfg.scale_q16        = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            step_ranger(req_start_req, req_echo_level, predicted);
            expected_words.push_back(predicted);
            if (predicted.done_res)
               done_count++;
            if (predicted.no_echo)
               no_echo_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               flag_error($sformatf("response word %0d arrived with nothing expected",
                                    rsp_index));
            end else begin
               wanted = expected_words.pop_front();
               if (rsp_trig_level !== wanted.trig_level)
                  flag_error($sformatf("word %0d trig_level: expected %0b, actual %0b",
                                       rsp_index, wanted.trig_level, rsp_trig_level));
               if (rsp_busy_res !== wanted.busy_res)
                  flag_error($sformatf("word %0d busy_res: expected %0b, actual %0b",
                                       rsp_index, wanted.busy_res, rsp_busy_res));
               if (rsp_done_res !== wanted.done_res)
                  flag_error($sformatf("word %0d done_res: expected %0b, actual %0b",
                                       rsp_index, wanted.done_res, rsp_done_res));
               if (rsp_no_echo !== wanted.no_echo)
                  flag_error($sformatf("word %0d no_echo: expected %0b, actual %0b",
                                       rsp_index, wanted.no_echo, rsp_no_echo));
               if (rsp_distance_x16 !== wanted.distance_x16)
                  flag_error($sformatf("word %0d distance_x16: expected %0d, actual %0d",
                                       rsp_index, wanted.distance_x16, rsp_distance_x16));
            end
            rsp_index++;
         end
      end
      pending  = expected_words.size();
      seq_idle = (ranger_phase == RANGER_IDLE);
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the ultrasonic echo ranger testbench: clock, reset, register setup and
// request stimulus with random idling. Depends on uer_pkg, the unit and uer_result_checker.
module testbench;

   localparam int CycleLimit     = 2000000;
   localparam int RandomWords    = 800;
   localparam int RandomSettings = 8;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_start_req;
   logic                              req_echo_level;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b1;
   logic                              rsp_trig_level;
   logic                              rsp_busy_res;
   logic                              rsp_done_res;
   logic                              rsp_no_echo;
   logic [15:0]                       rsp_distance_x16;
   logic                              csr_write;
   logic [uer_pkg::CsrIndexWidth-1:0] csr_index;
   logic [uer_pkg::CsrDataWidth-1:0]  csr_data;

   int               fail_count;
   int               pending;
   logic             seq_idle;
   int               done_count;
   int               no_echo_count;
   int               words_sent = 0;
   int               settings_loaded = 0;
   int               cycle_count = 0;
   int               stall_left = 0;
   bit               idling_on = 1'b1;
   uer_pkg::cfg_type applied_cfg;

   ultrasonic_echo_ranger_unit dut (.*);

   uer_result_checker result_check (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("ultrasonic_echo_ranger_unit test failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idling_on || roll < 60)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver side: random stalls while idling is enabled, always ready otherwise.
   always @(posedge clock) begin
      if (!idling_on) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < 30)
            stall_left <= pick_gap();
      end
   end

   function automatic int burst_ticks();
      int pulses;
      int half;
      pulses = (applied_cfg.pulse_count == '0) ? 1 : int'(applied_cfg.pulse_count);
      half   = (applied_cfg.pulse_half_us == '0) ? 1 : int'(applied_cfg.pulse_half_us);
      return 2 * half * pulses;
   endfunction

   function automatic int window_ticks();
      return (applied_cfg.window_us == '0) ? 1 : int'(applied_cfg.window_us);
   endfunction

   // Called right after a rising edge; returns at the edge that accepted the word,
   // with valid still high so that the next word can follow without a gap.
   task automatic send_word(input logic start, input logic level);
      int   gap;
      logic took;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_req  <= start;
      req_echo_level <= level;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      words_sent++;
   endtask

   // Writes every register whose value changes, and optionally the unmapped indexes.
   task automatic program_csr(input uer_pkg::cfg_type c, input bit spare);
      logic [uer_pkg::CsrIndexWidth-1:0] idx;
      logic [uer_pkg::CsrDataWidth-1:0]  value;
      logic [31:0]                       noise;
      bit                                changed;
      for (int i = 0; i < (1 << uer_pkg::CsrIndexWidth); i++) begin
         idx   = i[uer_pkg::CsrIndexWidth-1:0];
         value = '0;
         case (idx)
            uer_pkg::CSR_PULSE_COUNT: begin
               changed = (c.pulse_count != applied_cfg.pulse_count);
               value   = {16'd0, c.pulse_count};
            end
            uer_pkg::CSR_PULSE_HALF_US: begin
               changed = (c.pulse_half_us != applied_cfg.pulse_half_us);
               value   = {12'd0, c.pulse_half_us};
            end
            uer_pkg::CSR_COUNT_PERIOD_US: begin
               changed = (c.count_period_us != applied_cfg.count_period_us);
               value   = {12'd0, c.count_period_us};
            end
            uer_pkg::CSR_WINDOW_US: begin
               changed = (c.window_us != applied_cfg.window_us);
               value   = c.window_us;
            end
            uer_pkg::CSR_MAX_DISTANCE: begin
               changed = (c.max_distance_x16 != applied_cfg.max_distance_x16);
               value   = {4'd0, c.max_distance_x16};
            end
            uer_pkg::CSR_SCALE_Q16: begin
               changed = (c.scale_q16 != applied_cfg.scale_q16);
               value   = {4'd0, c.scale_q16};
            end
            default: begin
               changed = spare;
               noise   = $urandom;
               value   = noise[uer_pkg::CsrDataWidth-1:0];
            end
         endcase
         if (changed) begin
            csr_write <= 1'b1;
            csr_index <= idx;
            csr_data  <= value;
            @(posedge clock);
         end
      end
      csr_write   <= 1'b0;
      applied_cfg = c;
      settings_loaded++;
   endtask

   task automatic settle_idle();
      while (!seq_idle)
         send_word(1'b0, 1'($urandom));
   endtask

   // Brings the ranger back to idle and waits until every response has been taken.
   task automatic quiesce();
      settle_idle();
      req_valid <= 1'b0;
      while (pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One measurement: a start word, then one word per burst and window tick. The echo
   // is high from tick rise up to tick fall; glitch adds random levels after the fall.
   task automatic run_measurement(input int rise, input int fall, input bit glitch,
                                  input bit start_noise);
      int   span;
      logic level;
      span = burst_ticks() + window_ticks();
      send_word(1'b1, 1'b0);
      for (int k = 0; k < span; k++) begin
         if (glitch && k > fall)
            level = 1'($urandom);
         else
            level = (k >= rise && k < fall);
         send_word(start_noise ? 1'($urandom) : 1'b0, level);
      end
   endtask

   initial begin
      uer_pkg::cfg_type next_cfg;
      int               burst;
      int               span;
      int               phase_base;
      int               choice;
      int               rise;
      int               fall;
      int               lo;
      applied_cfg = '{pulse_count: uer_pkg::PULSE_COUNT_RESET,
                      pulse_half_us: uer_pkg::PULSE_HALF_US_RESET,
                      count_period_us: uer_pkg::COUNT_PERIOD_US_RESET,
                      window_us: uer_pkg::WINDOW_US_RESET,
                      max_distance_x16: uer_pkg::MAX_DISTANCE_RESET,
                      scale_q16: uer_pkg::SCALE_Q16_RESET};
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_start_req  <= 1'b0;
      req_echo_level <= 1'b0;
      csr_write      <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values everywhere except a short window.
      next_cfg           = applied_cfg;
      next_cfg.window_us = 20'd60;
      program_csr(next_cfg, 1'b0);
      burst = burst_ticks();
      run_measurement(burst + 3, burst + 20, 1'b0, 1'b1);
      quiesce();
      // Shorter trigger pulses keep the following cases brief.
      next_cfg.pulse_half_us = 8'd2;
      program_csr(next_cfg, 1'b0);
      burst = burst_ticks();
      span  = burst + window_ticks();
      // An echo pulse that ends inside the burst does not count.
      run_measurement(0, 10, 1'b0, 1'b0);
      settle_idle();
      // Falling edge on the first window tick gives a zero count.
      run_measurement(burst - 2, burst, 1'b0, 1'b0);
      settle_idle();
      run_measurement(burst + 1, burst + 30, 1'b1, 1'b0);
      settle_idle();
      // Echo held high through the whole window.
      run_measurement(burst, span + 3, 1'b0, 1'b0);
      quiesce();

      // Zero in every register, plus writes to the unmapped indexes.
      next_cfg = '0;
      program_csr(next_cfg, 1'b1);
      burst = burst_ticks();
      span  = burst + window_ticks();
      run_measurement(0, burst, 1'b0, 1'b0);
      settle_idle();
      run_measurement(0, span + 5, 1'b0, 1'b0);
      quiesce();

      idling_on = 1'b0;
      next_cfg  = '{pulse_count: 4'd15, pulse_half_us: 8'd1, count_period_us: 8'd1,
                    window_us: 20'd40, max_distance_x16: 16'hFFFF, scale_q16: 16'hFFFF};
      program_csr(next_cfg, 1'b0);
      burst = burst_ticks();
      run_measurement(burst + 2, burst + 32, 1'b0, 1'b0);
      quiesce();
      idling_on = 1'b1;

      // A ceiling of zero clamps the distance to zero, which repeats the last one.
      next_cfg = '{pulse_count: 4'd1, pulse_half_us: 8'd1, count_period_us: 8'd8,
                   window_us: 20'd60, max_distance_x16: 16'd0, scale_q16: 16'hFFFF};
      program_csr(next_cfg, 1'b0);
      burst = burst_ticks();
      run_measurement(2, burst + 50, 1'b0, 1'b0);
      quiesce();
      // A scale of one truncates a small count to zero.
      next_cfg.count_period_us  = 8'd1;
      next_cfg.window_us        = 20'd50;
      next_cfg.max_distance_x16 = 16'hFFFF;
      next_cfg.scale_q16        = 16'd1;
      program_csr(next_cfg, 1'b0);
      burst = burst_ticks();
      run_measurement(1, burst + 40, 1'b0, 1'b0);
      quiesce();

      // A large count at full scale runs into the ceiling.
      idling_on = 1'b0;
      next_cfg  = '{pulse_count: 4'd1, pulse_half_us: 8'd1, count_period_us: 8'd1,
                    window_us: 20'd60, max_distance_x16: 16'd400, scale_q16: 16'hFFFF};
      program_csr(next_cfg, 1'b0);
      burst = burst_ticks();
      run_measurement(0, burst + 50, 1'b0, 1'b0);
      quiesce();
      idling_on = 1'b1;

      // Longest window with idle words only.
      next_cfg.window_us       = 20'hFFFFF;
      next_cfg.count_period_us = 8'hFF;
      program_csr(next_cfg, 1'b0);
      repeat (24) send_word(1'b0, 1'($urandom));
      quiesce();

      for (int p = 0; p < RandomSettings; p++) begin
         choice = $urandom_range(0, 9);
         next_cfg.pulse_count = (choice == 0) ? 4'($urandom) : 4'($urandom_range(1, 3));
         choice = $urandom_range(0, 9);
         if (choice == 0)
            next_cfg.pulse_half_us = 8'd0;
         else if (choice == 1)
            next_cfg.pulse_half_us = 8'($urandom_range(5, 20));
         else
            next_cfg.pulse_half_us = 8'($urandom_range(1, 4));
         choice = $urandom_range(0, 19);
         if (choice < 2)
            next_cfg.count_period_us = 8'd0;
         else if (choice == 2)
            next_cfg.count_period_us = 8'hFF;
         else
            next_cfg.count_period_us = 8'($urandom_range(1, 6));
         choice = $urandom_range(0, 9);
         next_cfg.window_us = (choice == 0) ? 20'($urandom_range(0, 1))
                                            : 20'($urandom_range(4, 60));
         choice = $urandom_range(0, 9);
         if (choice < 3)
            next_cfg.max_distance_x16 = 16'($urandom_range(0, 400));
         else if (choice < 6)
            next_cfg.max_distance_x16 = 16'hFFFF;
         else
            next_cfg.max_distance_x16 = 16'($urandom);
         next_cfg.scale_q16 = ($urandom_range(0, 19) == 0) ? 16'd0
                                                          : 16'($urandom_range(1, 65535));
         program_csr(next_cfg, p == 0);
         phase_base = words_sent;
         while (words_sent - phase_base < RandomWords / RandomSettings) begin
            idling_on = ($urandom_range(0, 4) != 0);
            choice    = $urandom_range(0, 9);
            burst     = burst_ticks();
            span      = burst + window_ticks();
            if (choice < 8) begin
               settle_idle();
               rise = $urandom_range(0, span);
               lo   = (rise + 1 > burst) ? rise + 1 : burst;
               if ($urandom_range(0, 9) < 7 && lo <= span - 1)
                  fall = $urandom_range(lo, span - 1);
               else
                  fall = $urandom_range(rise + 1, span + 3);
               run_measurement(rise, fall, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            end else if (choice == 8) begin
               repeat ($urandom_range(3, 12)) send_word(1'($urandom), 1'($urandom));
            end else begin
               // A measurement cut short by random echo words.
               settle_idle();
               send_word(1'b1, 1'b0);
               repeat ($urandom_range(1, span)) send_word(1'b0, 1'($urandom));
            end
         end
         quiesce();
      end
      idling_on = 1'b1;

      repeat (10) @(posedge clock);
      $display("Sent %0d request words; %0d measurements completed, %0d of them without echo,",
               words_sent, done_count, no_echo_count);
      $display("over %0d register settings including zero and full-scale values.",
               settings_loaded);
      if (fail_count == 0 && pending == 0) begin
         $display("ultrasonic_echo_ranger_unit test passed");
      end else begin
         $display("ultrasonic_echo_ranger_unit test failed");
      end
      $finish;
   end

endmodule
